/* rtl/x86mov_pkg.sv */
// shared types, constants and helper functions for the mov decoder
package x86mov_pkg;

  localparam int unsigned NumBytes = 6;
  localparam int unsigned CntW     = $clog2(NumBytes + 1);

  // opcode masks and match values
  localparam logic [7:0] MaskRegmem  = 8'b11111100;
  localparam logic [7:0] MatchRegmem = 8'b10001000;
  localparam logic [7:0] MaskImmRm   = 8'b11111110;
  localparam logic [7:0] MatchImmRm  = 8'b11000110;
  localparam logic [7:0] MaskImmReg  = 8'b11110000;
  localparam logic [7:0] MatchImmReg = 8'b10110000;
  localparam logic [7:0] MaskAcc     = 8'b11111100;
  localparam logic [7:0] MatchAcc    = 8'b10100000;
  localparam logic [7:0] MaskRm      = 8'b00000111;

  localparam logic [1:0] ModMem0   = 2'd0;
  localparam logic [1:0] ModDisp8  = 2'd1;
  localparam logic [1:0] ModDisp16 = 2'd2;
  localparam logic [2:0] RmDirect  = 3'd6;

  typedef enum logic [2:0] {
    FormRegmem = 3'd0,
    FormImmRm  = 3'd1,
    FormImmReg = 3'd2,
    FormAcc    = 3'd3,
    FormBad    = 3'd4
  } form_e;

  typedef logic [NumBytes-1:0][7:0] byte_buf_t;

  typedef struct packed {
    form_e              form;
    logic               to_register;
    logic               wide;
    logic [1:0]         mode;
    logic [2:0]         reg_number;
    logic [2:0]         rm_number;
    logic               direct_address;
    logic signed [15:0] displacement;
    logic signed [15:0] immediate;
    logic               has_immediate;
    logic [2:0]         length;
  } mov_res_t;

  function automatic form_e classify(logic [7:0] op);
    form_e f;
    f = FormBad;
    if ((op & MaskRegmem) == MatchRegmem)      f = FormRegmem;
    else if ((op & MaskImmRm) == MatchImmRm)   f = FormImmRm;
    else if ((op & MaskImmReg) == MatchImmReg) f = FormImmReg;
    else if ((op & MaskAcc) == MatchAcc)       f = FormAcc;
    return f;
  endfunction

  // bytes covered by opcode, addressing byte and displacement
  function automatic logic [2:0] addr_end(logic [7:0] modrm);
    logic [2:0] e;
    case (modrm[7:6])
      ModDisp8:  e = 3'd3;
      ModDisp16: e = 3'd4;
      ModMem0:   e = ((modrm & MaskRm) == {5'd0, RmDirect}) ? 3'd4 : 3'd2;
      default:   e = 3'd2;
    endcase
    return e;
  endfunction

  function automatic logic [15:0] sx8(logic [7:0] b);
    return {{8{b[7]}}, b};
  endfunction

endpackage

/* rtl/x86mov_if.sv */
// handshake channels for code bytes and decoded instructions
interface x86mov_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;

  modport source (output valid, output code_byte, input ready);
  modport sink   (input valid, input code_byte, output ready);
endinterface

interface x86mov_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         form;
  logic               to_register;
  logic               wide;
  logic [1:0]         mode;
  logic [2:0]         reg_number;
  logic [2:0]         rm_number;
  logic               direct_address;
  logic signed [15:0] displacement;
  logic signed [15:0] immediate;
  logic               has_immediate;
  logic [2:0]         length;

  modport source (
    output valid, output form, output to_register, output wide, output mode,
    output reg_number, output rm_number, output direct_address,
    output displacement, output immediate, output has_immediate, output length,
    input ready
  );
  modport sink (
    input valid, input form, input to_register, input wide, input mode,
    input reg_number, input rm_number, input direct_address,
    input displacement, input immediate, input has_immediate, input length,
    output ready
  );
endinterface

/* rtl/x86_16_mov_decoder.sv */
// mov decoder: one result per instruction, one code byte per cycle
// the result register loads at the edge that takes the last byte
// throughput: one code byte per cycle, stalls only when the result is not taken
// instructions are 2 to 6 bytes long
// reset clears the byte count and the result valid; the byte buffer is not cleared
module x86_16_mov_decoder import x86mov_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  x86mov_in_if.sink     in_i,
  x86mov_out_if.source  out_o
);

  byte_buf_t        bytes_q;
  byte_buf_t        bytes_nxt;
  logic [CntW-1:0]  count_q, count_d;
  logic             out_valid_q, out_valid_d;
  mov_res_t         res_q;
  mov_res_t         res_dec;
  logic             done;
  logic             accept;

  assign in_i.ready = ~out_valid_q | out_o.ready;
  assign accept     = in_i.valid & in_i.ready;

  // buffer as it looks with the incoming byte in place
  always_comb begin
    for (int i = 0; i < NumBytes; i++) begin
      bytes_nxt[i] = (count_q == CntW'(i)) ? in_i.code_byte : bytes_q[i];
    end
  end

  x86mov_decode u_decode (
    .bytes_i (bytes_nxt),
    .count_i (count_q + CntW'(1)),
    .done_o  (done),
    .res_o   (res_dec)
  );

  always_comb begin
    count_d     = count_q;
    out_valid_d = out_valid_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (accept) begin
      count_d = done ? '0 : count_q + CntW'(1);
      if (done) begin
        out_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      bytes_q <= bytes_nxt;
      if (done) begin
        res_q <= res_dec;
      end
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.form           = res_q.form;
  assign out_o.to_register    = res_q.to_register;
  assign out_o.wide           = res_q.wide;
  assign out_o.mode           = res_q.mode;
  assign out_o.reg_number     = res_q.reg_number;
  assign out_o.rm_number      = res_q.rm_number;
  assign out_o.direct_address = res_q.direct_address;
  assign out_o.displacement   = res_q.displacement;
  assign out_o.immediate      = res_q.immediate;
  assign out_o.has_immediate  = res_q.has_immediate;
  assign out_o.length         = res_q.length;

endmodule

/* rtl/x86mov_decode.sv */
// combinational length check and field extraction over the gathered bytes
module x86mov_decode import x86mov_pkg::*; (
  input  byte_buf_t        bytes_i,
  input  logic [CntW-1:0]  count_i,
  output logic             done_o,
  output mov_res_t         res_o
);

  logic [7:0]  op;
  logic [7:0]  modrm;
  form_e       form;
  logic [2:0]  end_idx;
  logic [2:0]  need;
  logic [7:0]  imm_lo;
  logic [7:0]  imm_hi;

  assign op    = bytes_i[0];
  assign modrm = bytes_i[1];
  assign form  = classify(op);

  assign end_idx = addr_end(modrm);

  always_comb begin
    case (form)
      FormImmReg: need = 3'd2 + {2'd0, op[3]};
      FormAcc:    need = 3'd3;
      FormBad:    need = 3'd2;
      FormRegmem: need = (count_i < CntW'(2)) ? 3'd0 : end_idx;
      FormImmRm:  need = (count_i < CntW'(2)) ? 3'd0 : end_idx + 3'd1 + {2'd0, op[0]};
      default:    need = 3'd0;
    endcase
  end

  assign done_o = (need != 3'd0) && (count_i >= CntW'(need));

  // immediate of the immediate-to-r/m form sits right after the addressing bytes
  always_comb begin
    case (end_idx)
      3'd3:    begin imm_lo = bytes_i[3]; imm_hi = bytes_i[4]; end
      3'd4:    begin imm_lo = bytes_i[4]; imm_hi = bytes_i[5]; end
      default: begin imm_lo = bytes_i[2]; imm_hi = bytes_i[3]; end
    endcase
  end

  always_comb begin
    res_o        = '0;
    res_o.form   = form;
    res_o.length = need;
    case (form)
      FormRegmem, FormImmRm: begin
        res_o.to_register    = (form == FormRegmem) ? op[1] : 1'b0;
        res_o.wide           = op[0];
        res_o.mode           = modrm[7:6];
        res_o.reg_number     = modrm[5:3];
        res_o.rm_number      = modrm[2:0];
        res_o.direct_address = (modrm[7:6] == ModMem0) && (modrm[2:0] == RmDirect);
        if (modrm[7:6] == ModDisp8) begin
          res_o.displacement = sx8(bytes_i[2]);
        end else if (end_idx == 3'd4) begin
          res_o.displacement = {bytes_i[3], bytes_i[2]};
        end
        if (form == FormImmRm) begin
          res_o.immediate     = op[0] ? {imm_hi, imm_lo} : sx8(imm_lo);
          res_o.has_immediate = 1'b1;
        end
      end
      FormImmReg: begin
        res_o.to_register   = 1'b1;
        res_o.wide          = op[3];
        res_o.reg_number    = op[2:0];
        res_o.immediate     = op[3] ? {bytes_i[2], bytes_i[1]} : sx8(bytes_i[1]);
        res_o.has_immediate = 1'b1;
      end
      FormAcc: begin
        res_o.to_register    = ~op[1];
        res_o.wide           = op[0];
        res_o.rm_number      = RmDirect;
        res_o.direct_address = 1'b1;
        res_o.displacement   = {bytes_i[2], bytes_i[1]};
      end
      default: begin
        res_o.form   = FormBad;
      end
    endcase
  end

endmodule

/* sim/tb_x86_16_mov_decoder.sv */
// self-checking testbench for the x86 16-bit mov decoder
module tb_x86_16_mov_decoder;
  import x86mov_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ResetCycles = 12;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned TailCycles  = 10;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned NumDir      = 25;

  typedef struct {
    logic [7:0]  code [6];
    int unsigned n;
    bit          lit;
    mov_res_t    want;
  } dir_row_t;

  // fixed instructions; rows with lit set carry their decoded form
  dir_row_t dir_tbl [NumDir] = '{
    '{'{8'h89, 8'hD8, 8'h00, 8'h00, 8'h00, 8'h00}, 2, 1'b1,
      '{FormRegmem, 1'b0, 1'b1, 2'd3, 3'd3, 3'd0, 1'b0, 16'h0000, 16'h0000, 1'b0, 3'd2}},
    '{'{8'h8A, 8'h06, 8'h34, 8'h12, 8'h00, 8'h00}, 4, 1'b1,
      '{FormRegmem, 1'b1, 1'b0, 2'd0, 3'd0, 3'd6, 1'b1, 16'h1234, 16'h0000, 1'b0, 3'd4}},
    '{'{8'h88, 8'h47, 8'h80, 8'h00, 8'h00, 8'h00}, 3, 1'b0, '0},
    '{'{8'h8B, 8'h87, 8'hFF, 8'h7F, 8'h00, 8'h00}, 4, 1'b0, '0},
    '{'{8'h89, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 2, 1'b0, '0},
    '{'{8'h8B, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00}, 2, 1'b0, '0},
    '{'{8'hC6, 8'hC0, 8'h7F, 8'h00, 8'h00, 8'h00}, 3, 1'b0, '0},
    '{'{8'hC7, 8'hC3, 8'h00, 8'h80, 8'h00, 8'h00}, 4, 1'b0, '0},
    '{'{8'hC6, 8'h06, 8'h00, 8'h10, 8'hFF, 8'h00}, 5, 1'b0, '0},
    '{'{8'hC7, 8'h86, 8'h01, 8'h02, 8'hFF, 8'hFF}, 6, 1'b0, '0},
    '{'{8'hC6, 8'h45, 8'h80, 8'h01, 8'h00, 8'h00}, 4, 1'b0, '0},
    '{'{8'hC6, 8'hF8, 8'h12, 8'h00, 8'h00, 8'h00}, 3, 1'b0, '0},
    '{'{8'hB0, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00}, 2, 1'b1,
      '{FormImmReg, 1'b1, 1'b0, 2'd0, 3'd0, 3'd0, 1'b0, 16'h0000, 16'hFF80, 1'b1, 3'd2}},
    '{'{8'hBF, 8'hFF, 8'h7F, 8'h00, 8'h00, 8'h00}, 3, 1'b1,
      '{FormImmReg, 1'b1, 1'b1, 2'd0, 3'd7, 3'd0, 1'b0, 16'h0000, 16'h7FFF, 1'b1, 3'd3}},
    '{'{8'hB8, 8'h00, 8'h80, 8'h00, 8'h00, 8'h00}, 3, 1'b0, '0},
    '{'{8'hA0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 3, 1'b1,
      '{FormAcc, 1'b1, 1'b0, 2'd0, 3'd0, 3'd6, 1'b1, 16'h0000, 16'h0000, 1'b0, 3'd3}},
    '{'{8'hA3, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00}, 3, 1'b1,
      '{FormAcc, 1'b0, 1'b1, 2'd0, 3'd0, 3'd6, 1'b1, 16'hFFFF, 16'h0000, 1'b0, 3'd3}},
    '{'{8'hA1, 8'h00, 8'h80, 8'h00, 8'h00, 8'h00}, 3, 1'b0, '0},
    '{'{8'hA2, 8'h34, 8'h12, 8'h00, 8'h00, 8'h00}, 3, 1'b0, '0},
    '{'{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 2, 1'b1,
      '{FormBad, 1'b0, 1'b0, 2'd0, 3'd0, 3'd0, 1'b0, 16'h0000, 16'h0000, 1'b0, 3'd2}},
    '{'{8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00}, 2, 1'b1,
      '{FormBad, 1'b0, 1'b0, 2'd0, 3'd0, 3'd0, 1'b0, 16'h0000, 16'h0000, 1'b0, 3'd2}},
    '{'{8'hA4, 8'h88, 8'h00, 8'h00, 8'h00, 8'h00}, 2, 1'b1,
      '{FormBad, 1'b0, 1'b0, 2'd0, 3'd0, 3'd0, 1'b0, 16'h0000, 16'h0000, 1'b0, 3'd2}},
    '{'{8'hAF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 2, 1'b1,
      '{FormBad, 1'b0, 1'b0, 2'd0, 3'd0, 3'd0, 1'b0, 16'h0000, 16'h0000, 1'b0, 3'd2}},
    '{'{8'h8C, 8'hC0, 8'h00, 8'h00, 8'h00, 8'h00}, 2, 1'b1,
      '{FormBad, 1'b0, 1'b0, 2'd0, 3'd0, 3'd0, 1'b0, 16'h0000, 16'h0000, 1'b0, 3'd2}},
    '{'{8'hC8, 8'hB0, 8'h00, 8'h00, 8'h00, 8'h00}, 2, 1'b1,
      '{FormBad, 1'b0, 1'b0, 2'd0, 3'd0, 3'd0, 1'b0, 16'h0000, 16'h0000, 1'b0, 3'd2}}
  };

  logic clk = 1'b0;
  logic rst_n;

  x86mov_in_if  in_if ();
  x86mov_out_if out_if ();

  x86_16_mov_decoder dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // decoder model state
  logic [7:0]  gath_bytes [NumBytes];
  int unsigned gath_cnt;

  mov_res_t    decoded_q [$];
  int unsigned n_err;

  bit snd_idle;
  bit rcv_idle;
  bit hold_req;

  function automatic form_e opcode_form(logic [7:0] op);
    casez (op)
      8'b100010??: return FormRegmem;
      8'b1100011?: return FormImmRm;
      8'b1011????: return FormImmReg;
      8'b101000??: return FormAcc;
      default:     return FormBad;
    endcase
  endfunction

  // bytes taken by opcode, mod-r/m byte and displacement
  function automatic int unsigned ea_span(logic [7:0] modrm);
    case (modrm[7:6])
      2'd3:    return 2;
      2'd2:    return 4;
      2'd1:    return 3;
      default: return (modrm[2:0] == RmDirect) ? 4 : 2;
    endcase
  endfunction

  // gathers one code byte, returns 1 with the decoded instruction once complete
  function automatic bit decode_byte(input logic [7:0] b, output mov_res_t r);
    form_e       f;
    logic [7:0]  op;
    logic [7:0]  m;
    int unsigned need;
    int unsigned stop;
    r = '0;
    if (gath_cnt >= NumBytes) gath_cnt = 0;
    gath_bytes[gath_cnt] = b;
    gath_cnt++;
    op = gath_bytes[0];
    m  = gath_bytes[1];
    f  = opcode_form(op);
    case (f)
      FormImmReg: need = 2 + op[3];
      FormAcc:    need = 3;
      FormBad:    need = 2;
      FormRegmem: need = (gath_cnt < 2) ? 0 : ea_span(m);
      default:    need = (gath_cnt < 2) ? 0 : ea_span(m) + 1 + op[0];
    endcase
    if (need == 0 || gath_cnt < need) return 1'b0;
    r.form   = f;
    r.length = 3'(need);
    case (f)
      FormRegmem, FormImmRm: begin
        stop = ea_span(m);
        r.to_register    = (f == FormRegmem) ? op[1] : 1'b0;
        r.wide           = op[0];
        r.mode           = m[7:6];
        r.reg_number     = m[5:3];
        r.rm_number      = m[2:0];
        r.direct_address = (m[7:6] == ModMem0) && (m[2:0] == RmDirect);
        if (m[7:6] == ModDisp8)
          r.displacement = {{8{gath_bytes[2][7]}}, gath_bytes[2]};
        else if (stop == 4)
          r.displacement = {gath_bytes[3], gath_bytes[2]};
        if (f == FormImmRm) begin
          r.immediate = op[0] ? {gath_bytes[stop+1], gath_bytes[stop]}
                              : {{8{gath_bytes[stop][7]}}, gath_bytes[stop]};
          r.has_immediate = 1'b1;
        end
      end
      FormImmReg: begin
        r.to_register   = 1'b1;
        r.wide          = op[3];
        r.reg_number    = op[2:0];
        r.immediate     = op[3] ? {gath_bytes[2], gath_bytes[1]}
                                : {{8{gath_bytes[1][7]}}, gath_bytes[1]};
        r.has_immediate = 1'b1;
      end
      FormAcc: begin
        r.to_register    = ~op[1];
        r.wide           = op[0];
        r.rm_number      = RmDirect;
        r.direct_address = 1'b1;
        r.displacement   = {gath_bytes[2], gath_bytes[1]};
      end
      default: ;
    endcase
    gath_cnt = 0;
    return 1'b1;
  endfunction

  task automatic cmp_field(input string fld, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", fld, want, got);
      n_err++;
    end
  endtask

  // result monitor
  always @(posedge clk) begin
    mov_res_t w;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (decoded_q.size() == 0) begin
        $error("result transaction with no instruction pending");
        n_err++;
      end else begin
        w = decoded_q.pop_front();
        cmp_field("form", 16'(w.form), 16'(out_if.form));
        cmp_field("to_register", 16'(w.to_register), 16'(out_if.to_register));
        cmp_field("wide", 16'(w.wide), 16'(out_if.wide));
        cmp_field("mode", 16'(w.mode), 16'(out_if.mode));
        cmp_field("reg_number", 16'(w.reg_number), 16'(out_if.reg_number));
        cmp_field("rm_number", 16'(w.rm_number), 16'(out_if.rm_number));
        cmp_field("direct_address", 16'(w.direct_address), 16'(out_if.direct_address));
        cmp_field("displacement", w.displacement, out_if.displacement);
        cmp_field("immediate", w.immediate, out_if.immediate);
        cmp_field("has_immediate", 16'(w.has_immediate), 16'(out_if.has_immediate));
        cmp_field("length", 16'(w.length), 16'(out_if.length));
      end
    end
  end

  // result receiver with random stalls and one long hold-off
  initial begin
    int unsigned w;
    out_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      w = rcv_idle ? $urandom_range(0, 5) : 0;
      if (hold_req) begin
        w        = HoldCycles;
        hold_req = 1'b0;
      end
      if (w > 0) begin
        out_if.ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
    end
  end

  initial begin
    int unsigned cyc;
    cyc = 0;
    while (cyc < CycleLimit) begin
      @(posedge clk);
      cyc++;
    end
    $display("Verification failed");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input bit use_lit, input mov_res_t lit);
    int unsigned gap;
    mov_res_t    r;
    gap = snd_idle ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.code_byte <= b;
    do @(posedge clk); while (!in_if.ready);
    if (decode_byte(b, r)) decoded_q.push_back(use_lit ? lit : r);
  endtask

  // sender pause until every decoded instruction has come out
  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(posedge clk);
    wait (decoded_q.size() == 0);
    @(posedge clk);
  endtask

  // one well-formed instruction with random content, or a bit of noise
  task automatic send_random_instr(inout int unsigned sent);
    logic [7:0]  code [6];
    int unsigned n;
    int unsigned k;
    for (int i = 0; i < 6; i++) code[i] = 8'($urandom);
    k = $urandom_range(0, 99);
    if (k < 50) begin
      code[0] = (k < 30) ? {6'b100010, code[0][1:0]} : {7'b1100011, code[0][0]};
      if ($urandom_range(0, 9) == 0) code[1] = {2'd0, code[1][5:3], RmDirect};
      n = ea_span(code[1]);
      if (k >= 30) n = n + 1 + code[0][0];
    end else if (k < 70) begin
      code[0] = {4'b1011, code[0][3:0]};
      n = 2 + code[0][3];
    end else if (k < 80) begin
      code[0] = {6'b101000, code[0][1:0]};
      n = 3;
    end else begin
      n = $urandom_range(1, 3);
    end
    for (int i = 0; i < n; i++) send_byte(code[i], 1'b0, '0);
    sent += n;
  endtask

  initial begin
    int unsigned sent;
    int unsigned quota;
    n_err    = 0;
    gath_cnt = 0;
    sent     = 0;
    snd_idle = 1'b1;
    rcv_idle = 1'b1;
    hold_req = 1'b0;
    rst_n           <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.code_byte <= 8'h00;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NumDir; i++)
      for (int j = 0; j < dir_tbl[i].n; j++)
        send_byte(dir_tbl[i].code[j], dir_tbl[i].lit && (j == dir_tbl[i].n - 1),
                  dir_tbl[i].want);
    drain_results();

    // every mix of sender and receiver idling, then a back-pressure burst
    for (int ph = 0; ph < 5; ph++) begin
      snd_idle = (ph < 4) ? ph[0] : 1'b0;
      rcv_idle = (ph < 4) ? ph[1] : 1'b0;
      if (ph == 4) hold_req = 1'b1;
      quota = sent + ((ph == 4) ? 200 : 275);
      while (sent < quota) send_random_instr(sent);
      drain_results();
    end

    in_if.valid <= 1'b0;
    wait (decoded_q.size() == 0);
    repeat (TailCycles) @(posedge clk);
    if (n_err == 0 && decoded_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
